// ===== rtl/core/actuated_two_lane_signal_controller_defines.svh =====
// Assertion macros used by the checker of the signal controller.
`ifndef ACTUATED_TWO_LANE_SIGNAL_CONTROLLER_DEFINES_SVH
`define ACTUATED_TWO_LANE_SIGNAL_CONTROLLER_DEFINES_SVH

// Clocked property, quiet while reset is held.
`define ATLSC_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("atlsc check failed");

// Same-cycle implication.
`define ATLSC_ASSERT_IMP(label, ante, cons) \
    `ATLSC_ASSERT(label, (ante) |-> (cons))

`endif

// ===== rtl/core/atlsc_pkg.sv =====
package atlsc_pkg;

    // sliding window
    localparam int WINDOW    = 20;
    localparam int ECHO_BITS = 16;
    localparam int HEAD_BITS = $clog2(WINDOW);
    localparam int SEEN_BITS = $clog2(WINDOW + 1);
    localparam int SUM_BITS  = ECHO_BITS + $clog2(WINDOW);
    localparam int NEAR_BITS = 16;
    localparam int THR_BITS  = NEAR_BITS + $clog2(WINDOW);
    localparam int CMP_BITS  = (SUM_BITS > THR_BITS) ? SUM_BITS : THR_BITS;
    localparam logic [HEAD_BITS-1:0] HEAD_LAST = HEAD_BITS'(WINDOW - 1);
    localparam logic [SEEN_BITS-1:0] SEEN_FULL = SEEN_BITS'(WINDOW);

    // light machine
    localparam int LAMP_BITS  = 3;
    localparam int PHASE_BITS = 3;
    localparam int TICK_BITS  = 8;

    localparam logic [LAMP_BITS-1:0] LAMP_OFF    = 3'b000;
    localparam logic [LAMP_BITS-1:0] LAMP_GREEN  = 3'b001;
    localparam logic [LAMP_BITS-1:0] LAMP_YELLOW = 3'b010;
    localparam logic [LAMP_BITS-1:0] LAMP_RED    = 3'b100;

    localparam logic [PHASE_BITS-1:0] PH_INIT       = 3'd0;
    localparam logic [PHASE_BITS-1:0] PH_RED_GO     = 3'd1;
    localparam logic [PHASE_BITS-1:0] PH_BLUE_GO    = 3'd2;
    localparam logic [PHASE_BITS-1:0] PH_RED_TIMED  = 3'd3;
    localparam logic [PHASE_BITS-1:0] PH_BLUE_TIMED = 3'd4;
    localparam logic [PHASE_BITS-1:0] PH_YELLOW     = 3'd5;
    localparam logic [PHASE_BITS-1:0] PH_ALL_RED    = 3'd6;

    // config port
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [CFG_IDX_BITS-1:0] CFG_RED_LIMIT  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BLUE_LIMIT = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_YELLOW     = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ALL_RED    = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_NEAR       = 3'd4;

    localparam logic [TICK_BITS-1:0] RST_RED_LIMIT  = 8'd120;
    localparam logic [TICK_BITS-1:0] RST_BLUE_LIMIT = 8'd60;
    localparam logic [TICK_BITS-1:0] RST_YELLOW     = 8'd5;
    localparam logic [TICK_BITS-1:0] RST_ALL_RED    = 8'd5;
    localparam logic [NEAR_BITS-1:0] RST_NEAR       = 16'd1450;

    typedef struct packed {
        logic [TICK_BITS-1:0] red_limit;
        logic [TICK_BITS-1:0] blue_limit;
        logic [TICK_BITS-1:0] yellow;
        logic [TICK_BITS-1:0] all_red;
        logic [NEAR_BITS-1:0] near;
    } t_cfg;

    typedef struct packed {
        logic take;   // sample beat accepted, read its window entry
        logic fire;   // sample applied to sums and flags
    } t_sense_ctl;

endpackage

// ===== rtl/core/actuated_two_lane_signal_controller.sv =====
// Two-lane actuated traffic signal controller.
// Input channel (i_valid / o_stall): one beat is either a sensor sample
// (i_req_type 0, one echo time per lane in us) or a light tick (i_req_type 1).
// Output channel (o_valid / i_stall): exactly one result beat per input beat,
// in order, showing lamps, phase and both lane waiting flags after that beat.
// Config channel (i_cfg_valid / o_cfg_ready): always ready; write only while
// no beat is in flight.
// Path: an accepted beat is held in the read stage and then in the output
// registers, where its result is offered. Throughput: one beat per cycle
// while o_stall is low; the read stage waits on the registered read of the
// window RAM, which is issued as the beat is accepted.
// A finished result waits in the output registers while the next beat is
// taken into the read stage; only with both holding does o_stall rise.
// Reset: synchronous, active low; phase init, lamps off, flags, sums and
// window pointers cleared, config back to defaults. The window RAM is not
// cleared: an entry read from it is used only after the window has filled once.
module actuated_two_lane_signal_controller (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // items in
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic                                  i_req_type,
    input  logic [atlsc_pkg::ECHO_BITS-1:0]       i_echo_red_us,
    input  logic [atlsc_pkg::ECHO_BITS-1:0]       i_echo_blue_us,
    // results out
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic [atlsc_pkg::LAMP_BITS-1:0]       o_red_lamp,
    output logic [atlsc_pkg::LAMP_BITS-1:0]       o_blue_lamp,
    output logic [atlsc_pkg::PHASE_BITS-1:0]      o_phase,
    output logic                                  o_red_waiting,
    output logic                                  o_blue_waiting,
    // config writes
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [atlsc_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  logic [atlsc_pkg::CFG_DATA_BITS-1:0]   i_cfg_data
);

    atlsc_pkg::t_cfg        r_cfg, n_cfg;
    atlsc_pkg::t_sense_ctl  sense_ctl;

    logic r_s0_valid, n_s0_valid;
    logic r_s0_tick;
    logic r_out_valid, n_out_valid;
    logic advance;   // output register can take a new result
    logic fire;      // read-stage beat is applied to state
    logic accept;
    logic red_flag, blue_flag;

    assign advance = !r_out_valid || !i_stall;
    assign fire    = r_s0_valid && advance;
    assign o_stall = r_s0_valid && !advance;
    assign accept  = i_valid && !o_stall;

    assign sense_ctl.take = accept && !i_req_type;
    assign sense_ctl.fire = fire && !r_s0_tick;

    always_comb begin
        n_s0_valid = r_s0_valid;
        if (accept) begin
            n_s0_valid = 1'b1;
        end else if (fire) begin
            n_s0_valid = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (fire) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    // config register file
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                atlsc_pkg::CFG_RED_LIMIT:
                    n_cfg.red_limit  = i_cfg_data[atlsc_pkg::TICK_BITS-1:0];
                atlsc_pkg::CFG_BLUE_LIMIT:
                    n_cfg.blue_limit = i_cfg_data[atlsc_pkg::TICK_BITS-1:0];
                atlsc_pkg::CFG_YELLOW:
                    n_cfg.yellow     = i_cfg_data[atlsc_pkg::TICK_BITS-1:0];
                atlsc_pkg::CFG_ALL_RED:
                    n_cfg.all_red    = i_cfg_data[atlsc_pkg::TICK_BITS-1:0];
                atlsc_pkg::CFG_NEAR:
                    n_cfg.near       = i_cfg_data[atlsc_pkg::NEAR_BITS-1:0];
                default: begin
                    n_cfg = r_cfg;   // unmapped index, dropped
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid       <= 1'b0;
            r_out_valid      <= 1'b0;
            r_cfg.red_limit  <= atlsc_pkg::RST_RED_LIMIT;
            r_cfg.blue_limit <= atlsc_pkg::RST_BLUE_LIMIT;
            r_cfg.yellow     <= atlsc_pkg::RST_YELLOW;
            r_cfg.all_red    <= atlsc_pkg::RST_ALL_RED;
            r_cfg.near       <= atlsc_pkg::RST_NEAR;
        end else begin
            r_s0_valid  <= n_s0_valid;
            r_out_valid <= n_out_valid;
            r_cfg       <= n_cfg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s0_tick <= i_req_type;
        end
    end

    // window RAM, running sums and waiting flags
    atlsc_sense u_sense (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (sense_ctl),
        .i_echo_red  (i_echo_red_us),
        .i_echo_blue (i_echo_blue_us),
        .i_near      (r_cfg.near),
        .o_red_flag  (red_flag),
        .o_blue_flag (blue_flag)
    );

    // phase machine; its registers double as the result payload
    atlsc_light u_light (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tick      (fire && r_s0_tick),
        .i_cfg       (r_cfg),
        .i_red_flag  (red_flag),
        .i_blue_flag (blue_flag),
        .o_phase     (o_phase),
        .o_red_lamp  (o_red_lamp),
        .o_blue_lamp (o_blue_lamp)
    );

    assign o_valid        = r_out_valid;
    assign o_red_waiting  = red_flag;
    assign o_blue_waiting = blue_flag;

endmodule

// ===== rtl/core/atlsc_ram.sv =====
module atlsc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 20
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/atlsc_sense.sv =====
module atlsc_sense (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  atlsc_pkg::t_sense_ctl               i_ctl,
    input  logic [atlsc_pkg::ECHO_BITS-1:0]     i_echo_red,
    input  logic [atlsc_pkg::ECHO_BITS-1:0]     i_echo_blue,
    input  logic [atlsc_pkg::NEAR_BITS-1:0]     i_near,
    output logic                                o_red_flag,
    output logic                                o_blue_flag
);

    localparam int EB = atlsc_pkg::ECHO_BITS;
    localparam int SB = atlsc_pkg::SUM_BITS;
    localparam int CB = atlsc_pkg::CMP_BITS;
    localparam int TB = atlsc_pkg::THR_BITS;

    logic [atlsc_pkg::HEAD_BITS-1:0] r_head, n_head;
    logic [atlsc_pkg::SEEN_BITS-1:0] r_seen, n_seen;
    logic [atlsc_pkg::HEAD_BITS-1:0] r_s0_head;
    logic                            r_s0_full;
    logic [EB-1:0]                   r_s0_echo_red, r_s0_echo_blue;
    logic [SB-1:0]                   r_red_sum, n_red_sum;
    logic [SB-1:0]                   r_blue_sum, n_blue_sum;
    logic                            r_red_flag, n_red_flag;
    logic                            r_blue_flag, n_blue_flag;
    logic [2*EB-1:0]                 rdata;
    logic [EB-1:0]                   old_red, old_blue;
    logic [TB-1:0]                   thr;
    logic                            take_full;

    // window entries of both lanes share one word
    atlsc_ram #(
        .WIDTH (2 * EB),
        .DEPTH (atlsc_pkg::WINDOW)
    ) u_win (
        .i_clk   (i_clk),
        .i_we    (i_ctl.fire),
        .i_waddr (r_s0_head),
        .i_wdata ({r_s0_echo_red, r_s0_echo_blue}),
        .i_re    (i_ctl.take),
        .i_raddr (r_head),
        .o_rdata (rdata)
    );

    assign take_full = (r_seen == atlsc_pkg::SEEN_FULL);

    always_comb begin
        n_head = r_head;
        n_seen = r_seen;
        if (i_ctl.take) begin
            n_head = (r_head == atlsc_pkg::HEAD_LAST) ? '0 : r_head + 1'b1;
            if (!take_full) begin
                n_seen = r_seen + 1'b1;
            end
        end
    end

    // entry is only subtracted once the window had filled
    assign old_red  = r_s0_full ? rdata[2*EB-1:EB] : '0;
    assign old_blue = r_s0_full ? rdata[EB-1:0]    : '0;
    assign thr      = TB'(i_near) * TB'(atlsc_pkg::WINDOW);

    always_comb begin
        n_red_sum   = r_red_sum;
        n_blue_sum  = r_blue_sum;
        n_red_flag  = r_red_flag;
        n_blue_flag = r_blue_flag;
        if (i_ctl.fire) begin
            n_red_sum  = r_red_sum - SB'(old_red) + SB'(r_s0_echo_red);
            n_blue_sum = r_blue_sum - SB'(old_blue) + SB'(r_s0_echo_blue);
            if (r_s0_full) begin
                n_red_flag  = (CB'(n_red_sum) < CB'(thr));
                n_blue_flag = (CB'(n_blue_sum) < CB'(thr));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_seen      <= '0;
            r_red_sum   <= '0;
            r_blue_sum  <= '0;
            r_red_flag  <= 1'b0;
            r_blue_flag <= 1'b0;
        end else begin
            r_head      <= n_head;
            r_seen      <= n_seen;
            r_red_sum   <= n_red_sum;
            r_blue_sum  <= n_blue_sum;
            r_red_flag  <= n_red_flag;
            r_blue_flag <= n_blue_flag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.take) begin
            r_s0_head      <= r_head;
            r_s0_full      <= take_full;
            r_s0_echo_red  <= i_echo_red;
            r_s0_echo_blue <= i_echo_blue;
        end
    end

    assign o_red_flag  = r_red_flag;
    assign o_blue_flag = r_blue_flag;

endmodule

// ===== rtl/core/atlsc_light.sv =====
module atlsc_light (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_tick,
    input  atlsc_pkg::t_cfg                      i_cfg,
    input  logic                                 i_red_flag,
    input  logic                                 i_blue_flag,
    output logic [atlsc_pkg::PHASE_BITS-1:0]     o_phase,
    output logic [atlsc_pkg::LAMP_BITS-1:0]      o_red_lamp,
    output logic [atlsc_pkg::LAMP_BITS-1:0]      o_blue_lamp
);

    logic [atlsc_pkg::PHASE_BITS-1:0] r_phase, n_phase;
    logic [atlsc_pkg::TICK_BITS-1:0]  r_dwell, n_dwell;
    logic                             r_last_red, n_last_red;
    logic [atlsc_pkg::LAMP_BITS-1:0]  r_red_lamp, n_red_lamp;
    logic [atlsc_pkg::LAMP_BITS-1:0]  r_blue_lamp, n_blue_lamp;
    logic                             r, b;

    assign r = i_red_flag;
    assign b = i_blue_flag;

    always_comb begin
        n_phase     = r_phase;
        n_dwell     = r_dwell;
        n_last_red  = r_last_red;
        n_red_lamp  = r_red_lamp;
        n_blue_lamp = r_blue_lamp;
        if (i_tick) begin
            unique case (r_phase)
                atlsc_pkg::PH_INIT: begin
                    n_red_lamp  = atlsc_pkg::LAMP_OFF;
                    n_blue_lamp = atlsc_pkg::LAMP_OFF;
                    n_dwell     = '0;
                    n_last_red  = 1'b0;
                    if (!b) begin
                        n_phase = atlsc_pkg::PH_RED_GO;
                    end else if (!r) begin
                        n_phase = atlsc_pkg::PH_BLUE_GO;
                    end else begin
                        n_phase = atlsc_pkg::PH_RED_TIMED;
                    end
                end
                atlsc_pkg::PH_RED_GO: begin
                    n_red_lamp  = atlsc_pkg::LAMP_GREEN;
                    n_blue_lamp = atlsc_pkg::LAMP_RED;
                    if (r && b) begin
                        n_phase = atlsc_pkg::PH_RED_TIMED;
                        n_dwell = '0;
                    end else if (b) begin
                        n_phase    = atlsc_pkg::PH_YELLOW;
                        n_red_lamp = atlsc_pkg::LAMP_YELLOW;
                        n_dwell    = '0;
                    end
                end
                atlsc_pkg::PH_BLUE_GO: begin
                    n_red_lamp  = atlsc_pkg::LAMP_RED;
                    n_blue_lamp = atlsc_pkg::LAMP_GREEN;
                    if (r || !b) begin
                        n_phase     = atlsc_pkg::PH_YELLOW;
                        n_blue_lamp = atlsc_pkg::LAMP_YELLOW;
                        n_dwell     = '0;
                    end
                end
                atlsc_pkg::PH_RED_TIMED: begin
                    n_red_lamp  = atlsc_pkg::LAMP_GREEN;
                    n_blue_lamp = atlsc_pkg::LAMP_RED;
                    if (r_dwell >= i_cfg.red_limit || !r) begin
                        n_phase    = atlsc_pkg::PH_YELLOW;
                        n_red_lamp = atlsc_pkg::LAMP_YELLOW;
                        n_dwell    = '0;
                        n_last_red = 1'b1;
                    end else begin
                        n_dwell = r_dwell + 1'b1;
                    end
                end
                atlsc_pkg::PH_BLUE_TIMED: begin
                    n_red_lamp  = atlsc_pkg::LAMP_RED;
                    n_blue_lamp = atlsc_pkg::LAMP_GREEN;
                    if (r_dwell >= i_cfg.blue_limit || !b) begin
                        n_phase     = atlsc_pkg::PH_YELLOW;
                        n_blue_lamp = atlsc_pkg::LAMP_YELLOW;
                        n_dwell     = '0;
                        n_last_red  = 1'b0;
                    end else begin
                        n_dwell = r_dwell + 1'b1;
                    end
                end
                atlsc_pkg::PH_YELLOW: begin
                    if (r_dwell >= i_cfg.yellow) begin
                        n_phase     = atlsc_pkg::PH_ALL_RED;
                        n_red_lamp  = atlsc_pkg::LAMP_RED;
                        n_blue_lamp = atlsc_pkg::LAMP_RED;
                        n_dwell     = '0;
                    end else begin
                        n_dwell = r_dwell + 1'b1;
                    end
                end
                atlsc_pkg::PH_ALL_RED: begin
                    if (r_dwell >= i_cfg.all_red) begin
                        if (!b) begin
                            n_phase    = atlsc_pkg::PH_RED_GO;
                            n_last_red = 1'b0;
                        end else if (!r) begin
                            n_phase    = atlsc_pkg::PH_BLUE_GO;
                            n_last_red = 1'b0;
                        end else if (r_last_red) begin
                            n_phase = atlsc_pkg::PH_BLUE_TIMED;
                        end else begin
                            n_phase = atlsc_pkg::PH_RED_TIMED;
                        end
                        n_dwell = '0;
                    end else begin
                        n_dwell = r_dwell + 1'b1;
                    end
                end
                default: begin
                    n_phase = atlsc_pkg::PH_INIT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= atlsc_pkg::PH_INIT;
            r_dwell     <= '0;
            r_last_red  <= 1'b0;
            r_red_lamp  <= atlsc_pkg::LAMP_OFF;
            r_blue_lamp <= atlsc_pkg::LAMP_OFF;
        end else begin
            r_phase     <= n_phase;
            r_dwell     <= n_dwell;
            r_last_red  <= n_last_red;
            r_red_lamp  <= n_red_lamp;
            r_blue_lamp <= n_blue_lamp;
        end
    end

    assign o_phase     = r_phase;
    assign o_red_lamp  = r_red_lamp;
    assign o_blue_lamp = r_blue_lamp;

endmodule

// ===== rtl/core/atlsc_checker.sv =====
`include "actuated_two_lane_signal_controller_defines.svh"

module atlsc_checker (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 o_valid,
    input  logic                                 i_stall,
    input  logic [atlsc_pkg::PHASE_BITS-1:0]     o_phase,
    input  logic [atlsc_pkg::LAMP_BITS-1:0]      o_red_lamp,
    input  logic [atlsc_pkg::LAMP_BITS-1:0]      o_blue_lamp
);

    logic red_green;
    logic blue_green;
    logic both_red;
    logic in_all_red;

    assign red_green  = (o_red_lamp == atlsc_pkg::LAMP_GREEN);
    assign blue_green = (o_blue_lamp == atlsc_pkg::LAMP_GREEN);
    assign both_red   = (o_red_lamp == atlsc_pkg::LAMP_RED) &&
                        (o_blue_lamp == atlsc_pkg::LAMP_RED);
    assign in_all_red = (o_phase == atlsc_pkg::PH_ALL_RED);

    // a held result beat stays offered
    `ATLSC_ASSERT(a_hold_valid, o_valid && i_stall |=> o_valid)

    // never green on both lanes
    `ATLSC_ASSERT(a_one_green, !(red_green && blue_green))

    // all-red phase shows red on both lanes
    `ATLSC_ASSERT_IMP(a_all_red, in_all_red, both_red)

    // a phase change is always carried by a result beat
    `ATLSC_ASSERT_IMP(a_phase_beat, !$stable(o_phase), o_valid)

endmodule

bind actuated_two_lane_signal_controller atlsc_checker u_atlsc_checker (.*);
